// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define SDD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define SDD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sdd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdd_pkg
// Shared types, constants and helpers of the stereo diffusion delay.
// ---------------------------------------------------------------------------
package sdd_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int CSR_AW              = 5;
   localparam int DELAY_DEPTH_DEF     = 65536;
   localparam int ALLPASS_DEPTH_DEF   = 2048;
   localparam int STAGE_COUNT_DEF     = 4;

   // register map (index = byte address / 4)
   localparam logic [2:0] REG_DELAY_TIME = 3'd0;
   localparam logic [2:0] REG_FEEDBACK   = 3'd1;
   localparam logic [2:0] REG_DIFFUSION  = 3'd2;
   localparam logic [2:0] REG_WET_MIX    = 3'd3;
   localparam logic [2:0] REG_AP_DELAY_1 = 3'd4;
   localparam logic [2:0] REG_AP_DELAY_2 = 3'd5;
   localparam logic [2:0] REG_AP_DELAY_3 = 3'd6;
   localparam logic [2:0] REG_AP_DELAY_4 = 3'd7;

   // reset values
   localparam logic [23:0] RST_DELAY_TIME = 24'd6144000;
   localparam logic [15:0] RST_FEEDBACK   = 16'd32768;
   localparam logic [15:0] RST_DIFFUSION  = 16'd32768;
   localparam logic [16:0] RST_WET_MIX    = 17'd32768;
   localparam logic [10:0] RST_AP_DELAY_1 = 11'd150;
   localparam logic [10:0] RST_AP_DELAY_2 = 11'd250;
   localparam logic [10:0] RST_AP_DELAY_3 = 11'd400;
   localparam logic [10:0] RST_AP_DELAY_4 = 11'd600;

   // gain limits and coefficient terms
   localparam logic [15:0] FB_MAX    = 16'd62259;
   localparam logic [16:0] MIX_MAX   = 17'd65536;
   localparam logic [15:0] G_OFFSET  = 16'd19661;
   localparam logic [15:0] G_SLOPE   = 16'd39322;

   typedef struct packed {
      logic [23:0]      delay_time;
      logic [15:0]      feedback_gain;
      logic [15:0]      diffusion_amount;
      logic [16:0]      wet_mix;
      logic [3:0][10:0] ap_delay;
   } sdd_cfg_type;

   // beat handed from one allpass stage to the next
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] wet_l;
      logic signed [SAMPLE_W-1:0] wet_r;
      logic                       clip;
   } sdd_link_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_INTERP,
      S_CHAIN,
      S_DONE
   } sdd_state_type;

   // saturate to a Q1.15 sample; bit 16 flags clipping
   function automatic logic [16:0] sat_sample(input logic signed [19:0] v);
      logic [16:0] r;
      if (v > 20'sd32767) begin
         r = {1'b1, 16'h7FFF};
      end else if (v < -20'sd32768) begin
         r = {1'b1, 16'h8000};
      end else begin
         r = {1'b0, v[15:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/sdd_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdd_csr
// APB register file holding the delay, gain, mix and allpass settings.
// ---------------------------------------------------------------------------
module sdd_csr import sdd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output sdd_cfg_type       cfg
);

   sdd_cfg_type cfg_ff;
   sdd_cfg_type cfg_in;
   logic [2:0]  index;
   logic        wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_DELAY_TIME: cfg_in.delay_time       = csr_pwdata[23:0];
            REG_FEEDBACK:   cfg_in.feedback_gain    = csr_pwdata[15:0];
            REG_DIFFUSION:  cfg_in.diffusion_amount = csr_pwdata[15:0];
            REG_WET_MIX:    cfg_in.wet_mix          = csr_pwdata[16:0];
            REG_AP_DELAY_1: cfg_in.ap_delay[0]      = csr_pwdata[10:0];
            REG_AP_DELAY_2: cfg_in.ap_delay[1]      = csr_pwdata[10:0];
            REG_AP_DELAY_3: cfg_in.ap_delay[2]      = csr_pwdata[10:0];
            REG_AP_DELAY_4: cfg_in.ap_delay[3]      = csr_pwdata[10:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_time       <= RST_DELAY_TIME;
         cfg_ff.feedback_gain    <= RST_FEEDBACK;
         cfg_ff.diffusion_amount <= RST_DIFFUSION;
         cfg_ff.wet_mix          <= RST_WET_MIX;
         cfg_ff.ap_delay[0]      <= RST_AP_DELAY_1;
         cfg_ff.ap_delay[1]      <= RST_AP_DELAY_2;
         cfg_ff.ap_delay[2]      <= RST_AP_DELAY_3;
         cfg_ff.ap_delay[3]      <= RST_AP_DELAY_4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         REG_DELAY_TIME: csr_prdata = 32'(cfg_ff.delay_time);
         REG_FEEDBACK:   csr_prdata = 32'(cfg_ff.feedback_gain);
         REG_DIFFUSION:  csr_prdata = 32'(cfg_ff.diffusion_amount);
         REG_WET_MIX:    csr_prdata = 32'(cfg_ff.wet_mix);
         REG_AP_DELAY_1: csr_prdata = 32'(cfg_ff.ap_delay[0]);
         REG_AP_DELAY_2: csr_prdata = 32'(cfg_ff.ap_delay[1]);
         REG_AP_DELAY_3: csr_prdata = 32'(cfg_ff.ap_delay[2]);
         REG_AP_DELAY_4: csr_prdata = 32'(cfg_ff.ap_delay[3]);
         default:        csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== rtl/core/sdd_delay_line.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdd_delay_line
// Main delay memory of one channel: two registered read ports, one write.
// ---------------------------------------------------------------------------
module sdd_delay_line import sdd_pkg::*; #(
   parameter int DEPTH = DELAY_DEPTH_DEF,
   parameter int AW    = $clog2(DELAY_DEPTH_DEF)
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr0,
   input  logic [AW-1:0]              rd_addr1,
   output logic signed [SAMPLE_W-1:0] rd_data0,
   output logic signed [SAMPLE_W-1:0] rd_data1,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data
);

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd0_ff;
   logic signed [SAMPLE_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // both interpolation taps read in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ===== rtl/core/sdd_allpass_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdd_allpass_stage
// One allpass section for both channels, with its own store; passes the
// diffused pair on to the next stage in the cycle after it arrives.
// ---------------------------------------------------------------------------
module sdd_allpass_stage import sdd_pkg::*; #(
   parameter int ALLPASS_DEPTH = ALLPASS_DEPTH_DEF,
   parameter int AAW           = $clog2(ALLPASS_DEPTH_DEF)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           rd_en,
   input  logic [AAW-1:0] ap_ptr,
   input  logic           ap_full,
   input  logic [10:0]    delay,
   input  logic [15:0]    g,
   input  sdd_link_type   link_in,
   output sdd_link_type   link_out
);

   localparam logic [31:0] D_MAX = 32'(ALLPASS_DEPTH - 1);
   localparam logic [AAW:0] SPAN = (AAW + 1)'(ALLPASS_DEPTH);

   logic signed [SAMPLE_W-1:0] mem_l [ALLPASS_DEPTH];
   logic signed [SAMPLE_W-1:0] mem_r [ALLPASS_DEPTH];

   logic [31:0]                d_ext;
   logic [AAW-1:0]             d_clamp;
   logic [AAW:0]               rp_sum;
   logic [AAW-1:0]             rp;
   logic                       rd_ok;

   logic signed [SAMPLE_W-1:0] held_l_ff;
   logic signed [SAMPLE_W-1:0] held_r_ff;
   logic                       held_ok_ff;
   logic signed [SAMPLE_W-1:0] held_l;
   logic signed [SAMPLE_W-1:0] held_r;

   logic signed [16:0]         gs;
   logic [16:0]                st_l, st_r, out_l, out_r;

   sdd_link_type               link_ff;
   sdd_link_type               link_in_d;

   // clamped stage delay and read position
   always_comb begin
      d_ext = 32'(delay);
      if (d_ext < 32'd1) begin
         d_clamp = AAW'(1);
      end else if (d_ext > D_MAX) begin
         d_clamp = D_MAX[AAW-1:0];
      end else begin
         d_clamp = d_ext[AAW-1:0];
      end
      rp_sum = {1'b0, ap_ptr} + SPAN - {1'b0, d_clamp};
      if (rp_sum >= SPAN) begin
         rp_sum = rp_sum - SPAN;
      end
      rp    = rp_sum[AAW-1:0];
      rd_ok = ap_full | (rp < ap_ptr);
   end

   // held value, fetched at the start of the beat
   always_ff @(posedge clock) begin
      if (rd_en) begin
         held_l_ff  <= mem_l[rp];
         held_r_ff  <= mem_r[rp];
         held_ok_ff <= rd_ok;
      end
   end

   // entries not yet written read as zero
   assign held_l = held_ok_ff ? held_l_ff : '0;
   assign held_r = held_ok_ff ? held_r_ff : '0;
   assign gs     = $signed({1'b0, g});

   // store = wet + g*held, out = held - g*wet, both rounded and saturated
   function automatic logic [33:0] ap_math(input logic signed [16:0]         gv,
                                           input logic signed [SAMPLE_W-1:0] wet,
                                           input logic signed [SAMPLE_W-1:0] hv);
      logic signed [32:0] p_h, p_w;
      logic signed [16:0] r_h, r_w;
      logic signed [19:0] s_st, s_out;
      p_h   = gv * hv;
      p_w   = gv * wet;
      p_h   = p_h + 33'sd32768;
      p_w   = p_w + 33'sd32768;
      r_h   = $signed(p_h[32:16]);
      r_w   = $signed(p_w[32:16]);
      s_st  = 20'(wet) + 20'(r_h);
      s_out = 20'(hv) - 20'(r_w);
      return {sat_sample(s_st), sat_sample(s_out)};
   endfunction

   assign {st_l, out_l} = ap_math(gs, link_in.wet_l, held_l);
   assign {st_r, out_r} = ap_math(gs, link_in.wet_r, held_r);

   always_ff @(posedge clock) begin
      if (link_in.valid) begin
         mem_l[ap_ptr] <= st_l[15:0];
         mem_r[ap_ptr] <= st_r[15:0];
      end
   end

   // next beat of the chain
   always_comb begin
      link_in_d.valid = link_in.valid;
      link_in_d.wet_l = out_l[15:0];
      link_in_d.wet_r = out_r[15:0];
      link_in_d.clip  = link_in.clip | st_l[16] | st_r[16] | out_l[16] | out_r[16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_d.valid;
      end
      link_ff.wet_l <= link_in_d.wet_l;
      link_ff.wet_r <= link_in_d.wet_r;
      link_ff.clip  <= link_in_d.clip;
   end

   assign link_out = link_ff;

endmodule

// ===== rtl/core/stereo_diffusion_delay_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted input beat passes the fetch and interpolation states,
// the allpass stage row, the mix register and the done state to rsp_valid.
// One item at a time: it walks the stage row one stage per cycle; the next is accepted only back in idle.
// Reset: synchronous; pointers and fill flags clear at once, no memory sweep
// is run, unwritten delay and allpass entries read as zero.
// ---------------------------------------------------------------------------
// stereo_diffusion_delay_unit
// Stereo fractional delay with feedback through a row of allpass stages.
// ---------------------------------------------------------------------------
module stereo_diffusion_delay_unit import sdd_pkg::*; #(
   parameter int DELAY_DEPTH   = DELAY_DEPTH_DEF,
   parameter int ALLPASS_DEPTH = ALLPASS_DEPTH_DEF,
   parameter int STAGE_COUNT   = STAGE_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_left_sample,
   input  logic signed [SAMPLE_W-1:0] req_right_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_clipped,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

`include "assert_macros.svh"

   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int AAW = $clog2(ALLPASS_DEPTH);
   localparam int PW  = AW + 9;
   localparam logic [PW-1:0]  SPAN     = PW'(DELAY_DEPTH) << 8;
   localparam logic [31:0]    DMAX     = 32'(DELAY_DEPTH - 1) << 8;
   localparam logic [AW-1:0]  WP_LAST  = AW'(DELAY_DEPTH - 1);
   localparam logic [AAW-1:0] AP_LAST  = AAW'(ALLPASS_DEPTH - 1);

   sdd_cfg_type   cfg;
   sdd_state_type state_ff, state_in;

   logic accept, fetch_en, interp_en, mix_en, done_go;

   // per-item settings
   logic [AW+7:0]              dly_ff;
   logic [15:0]                g_ff, fb_ff;
   logic [16:0]                mix_ff;
   logic signed [SAMPLE_W-1:0] dry_l_ff, dry_r_ff;
   logic [31:0]                dt_ext, dly_c;
   logic [31:0]                g_prod;

   // pointers
   logic [AW-1:0]  wp_ff;
   logic           wp_full_ff;
   logic [AAW-1:0] ap_ff;
   logic           ap_full_ff;

   // delay-line read
   logic [PW-1:0]  pos;
   logic [AW-1:0]  i0, i1;
   logic [7:0]     frac_ff;
   logic           ok0_ff, ok1_ff;
   logic signed [SAMPLE_W-1:0] ld0, ld1, rd0, rd1;

   // allpass row
   sdd_link_type   links [STAGE_COUNT+1];
   sdd_link_type   link0_ff;
   logic [STAGE_COUNT-1:0] stage_valid;

   // mix results
   logic signed [SAMPLE_W-1:0] wr_l_ff, wr_r_ff, out_l_ff, out_r_ff;
   logic                       clip_ff;
   logic [16:0]                wl_s, wr_s, ol_s, or_s;

   // output register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_l_ff, rsp_r_ff;
   logic                       rsp_clip_ff;

   sdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_FETCH;
         S_FETCH:  state_in = S_INTERP;
         S_INTERP: state_in = S_CHAIN;
         S_CHAIN:  if (links[STAGE_COUNT].valid) state_in = S_DONE;
         S_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      fetch_en  = 1'b0;
      interp_en = 1'b0;
      mix_en    = 1'b0;
      done_go   = 1'b0;
      case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         S_FETCH:  fetch_en  = 1'b1;
         S_INTERP: interp_en = 1'b1;
         S_CHAIN:  mix_en    = links[STAGE_COUNT].valid;
         S_DONE:   done_go   = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- settings latched with the input beat ----
   always_comb begin
      dt_ext = 32'(cfg.delay_time);
      if (dt_ext < 32'd256) begin
         dly_c = 32'd256;
      end else if (dt_ext > DMAX) begin
         dly_c = DMAX;
      end else begin
         dly_c = dt_ext;
      end
      g_prod = 32'(G_SLOPE) * 32'(cfg.diffusion_amount) + 32'd32768;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dry_l_ff <= req_left_sample;
         dry_r_ff <= req_right_sample;
         dly_ff   <= dly_c[AW+7:0];
         g_ff     <= G_OFFSET + g_prod[31:16];
         fb_ff    <= (cfg.feedback_gain > FB_MAX) ? FB_MAX : cfg.feedback_gain;
         mix_ff   <= (cfg.wet_mix > MIX_MAX) ? MIX_MAX : cfg.wet_mix;
      end
   end

   // ---- fractional read position ----
   always_comb begin
      pos = ({1'b0, wp_ff, 8'd0}) + SPAN - PW'(dly_ff);
      if (pos >= SPAN) begin
         pos = pos - SPAN;
      end
      i0 = pos[AW+7:8];
      i1 = (i0 == WP_LAST) ? '0 : i0 + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (fetch_en) begin
         frac_ff <= pos[7:0];
         ok0_ff  <= wp_full_ff | (i0 < wp_ff);
         ok1_ff  <= wp_full_ff | (i1 < wp_ff);
      end
   end

   sdd_delay_line #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_line_l (
      .clock    (clock),
      .rd_en    (fetch_en),
      .rd_addr0 (i0),
      .rd_addr1 (i1),
      .rd_data0 (ld0),
      .rd_data1 (ld1),
      .wr_en    (done_go),
      .wr_addr  (wp_ff),
      .wr_data  (wr_l_ff)
   );

   sdd_delay_line #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_line_r (
      .clock    (clock),
      .rd_en    (fetch_en),
      .rd_addr0 (i0),
      .rd_addr1 (i1),
      .rd_data0 (rd0),
      .rd_data1 (rd1),
      .wr_en    (done_go),
      .wr_addr  (wp_ff),
      .wr_data  (wr_r_ff)
   );

   // ---- linear interpolation between the two taps ----
   function automatic logic signed [SAMPLE_W-1:0] interp(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b,
      input logic [7:0]                 f);
      logic signed [9:0]  wa, wb;
      logic signed [25:0] ma, mb;
      logic signed [26:0] s;
      wa = $signed({1'b0, 9'(9'd256 - {1'b0, f})});
      wb = $signed({2'b00, f});
      ma = a * wa;
      mb = b * wb;
      s  = 27'(ma) + 27'(mb) + 27'sd128;
      return s[23:8];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         link0_ff.valid <= 1'b0;
      end else begin
         link0_ff.valid <= interp_en;
      end
      link0_ff.wet_l <= interp(ok0_ff ? ld0 : '0, ok1_ff ? ld1 : '0, frac_ff);
      link0_ff.wet_r <= interp(ok0_ff ? rd0 : '0, ok1_ff ? rd1 : '0, frac_ff);
      link0_ff.clip  <= 1'b0;
   end

   // ---- row of allpass stages ----
   assign links[0] = link0_ff;

   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
      sdd_allpass_stage #(.ALLPASS_DEPTH(ALLPASS_DEPTH), .AAW(AAW)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .rd_en    (fetch_en),
         .ap_ptr   (ap_ff),
         .ap_full  (ap_full_ff),
         .delay    (cfg.ap_delay[s % 4]),
         .g        (g_ff),
         .link_in  (links[s]),
         .link_out (links[s+1])
      );
      assign stage_valid[s] = links[s+1].valid;
   end

   // ---- feedback write value and dry/wet mix ----
   function automatic logic [33:0] mix_math(input logic signed [SAMPLE_W-1:0] dry,
                                            input logic signed [SAMPLE_W-1:0] wet,
                                            input logic [15:0]                fb,
                                            input logic [16:0]                mix);
      logic signed [32:0] p_fb;
      logic signed [19:0] s_wr;
      logic signed [33:0] p_dry, p_wet;
      logic signed [34:0] s_mix;
      p_fb  = wet * $signed({1'b0, fb});
      p_fb  = p_fb + 33'sd32768;
      s_wr  = 20'(dry) + 20'($signed(p_fb[32:16]));
      p_dry = dry * $signed({1'b0, 17'(MIX_MAX - mix)});
      p_wet = wet * $signed({1'b0, mix});
      s_mix = 35'(p_dry) + 35'(p_wet) + 35'sd32768;
      return {sat_sample(s_wr), sat_sample(20'($signed(s_mix[34:16])))};
   endfunction

   assign {wl_s, ol_s} = mix_math(dry_l_ff, links[STAGE_COUNT].wet_l, fb_ff, mix_ff);
   assign {wr_s, or_s} = mix_math(dry_r_ff, links[STAGE_COUNT].wet_r, fb_ff, mix_ff);

   always_ff @(posedge clock) begin
      if (mix_en) begin
         wr_l_ff  <= wl_s[15:0];
         wr_r_ff  <= wr_s[15:0];
         out_l_ff <= ol_s[15:0];
         out_r_ff <= or_s[15:0];
         clip_ff  <= links[STAGE_COUNT].clip | wl_s[16] | wr_s[16] | ol_s[16] | or_s[16];
      end
   end

   // ---- pointers and fill flags ----
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wp_full_ff <= 1'b0;
         ap_ff      <= '0;
         ap_full_ff <= 1'b0;
      end else if (done_go) begin
         if (wp_ff == WP_LAST) begin
            wp_ff      <= '0;
            wp_full_ff <= 1'b1;
         end else begin
            wp_ff <= wp_ff + AW'(1);
         end
         if (ap_ff == AP_LAST) begin
            ap_ff      <= '0;
            ap_full_ff <= 1'b1;
         end else begin
            ap_ff <= ap_ff + AAW'(1);
         end
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done_go) begin
         rsp_l_ff    <= out_l_ff;
         rsp_r_ff    <= out_r_ff;
         rsp_clip_ff <= clip_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;
   assign rsp_clipped   = rsp_clip_ff;

   // ---- checks ----
   `SDD_ASSERT_ALWAYS(a_one_beat_in_row, clock, reset,
      $onehot0({stage_valid, link0_ff.valid}), "more than one beat in the stage row")
   `SDD_ASSERT_IMPLIES(a_chain_only_in_chain, clock, reset,
      |stage_valid, state_ff == S_CHAIN, "stage beat outside chain phase")
   `SDD_ASSERT_IMPLIES(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == S_DONE), "result not loaded from done phase")
   `SDD_ASSERT_IMPLIES(a_ptr_step, clock, reset,
      wp_ff != $past(wp_ff), ap_ff != $past(ap_ff), "delay and allpass pointers out of step")

endmodule
